// ----- design/tea_pkg.sv -----
`default_nettype none

package tea_pkg;

  // Full rounds of the cipher; each round takes two pipeline stages
  localparam int ROUNDS = 32;
  localparam int STAGES = 2 * ROUNDS;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  typedef logic [31:0] word_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_KEY_WORD_0     = 3'd0;
  localparam cfg_index_t CFG_KEY_WORD_1     = 3'd1;
  localparam cfg_index_t CFG_KEY_WORD_2     = 3'd2;
  localparam cfg_index_t CFG_KEY_WORD_3     = 3'd3;
  localparam cfg_index_t CFG_DECRYPT_SELECT = 3'd4;

  // Running sum seen by a round when encrypting (rounds count from zero)
  function automatic word_t enc_sum(input int round);
    word_t count;
    count = word_t'(round + 1);
    return word_t'(DELTA * count);
  endfunction

  // Running sum seen by a round when decrypting
  function automatic word_t dec_sum(input int round);
    word_t count;
    count = word_t'(ROUNDS - round);
    return word_t'(DELTA * count);
  endfunction

  // Shift, add and xor mixing of one word
  function automatic word_t mix(input word_t w, input word_t sum,
                                input word_t ka, input word_t kb);
    return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

// ----- design/tea_block_cipher_unit.sv -----
`default_nettype none

// Channel   Signals                                         Direction
// -------   ----------------------------------------------  ---------
// block     block_valid/block_ready, first_half, second_half  in
// result    result_valid/result_ready, result_first/_second   out
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data          in
//
// One word enters every cycle while block_ready is high. Each round is split
// into two half-round stages (one word update each), and a finished word
// then passes through the output register. Reset clears the keys, the mode
// and all valid bits. A stalled output register holds the pipeline only
// when its last stage is full; all stages move together, so gaps between
// words stay as they are.

module tea_block_cipher_unit
  import tea_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   block_valid,
  output      logic                   block_ready,
  input  wire logic [31:0]            first_half,
  input  wire logic [31:0]            second_half,
  output      logic                   result_valid,
  input  wire logic                   result_ready,
  output      logic [31:0]            result_first,
  output      logic [31:0]            result_second,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int LAST = STAGES - 1;

  // Configuration registers
  word_t key_word_0;
  word_t key_word_1;
  word_t key_word_2;
  word_t key_word_3;
  logic  decrypt_select;

  // Pipeline registers
  word_t a_q     [STAGES];
  word_t b_q     [STAGES];
  logic  mode_q  [STAGES];
  logic  valid_q [STAGES];

  // Stage inputs and next values
  word_t a_in    [STAGES];
  word_t b_in    [STAGES];
  logic  mode_in [STAGES];
  logic  valid_in[STAGES];
  word_t a_next  [STAGES];
  word_t b_next  [STAGES];

  logic out_load;
  logic advance;

  assign cfg_ready = 1'b1;

  // Take register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0     <= '0;
      key_word_1     <= '0;
      key_word_2     <= '0;
      key_word_3     <= '0;
      decrypt_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_WORD_0:     key_word_0     <= cfg_data;
        CFG_KEY_WORD_1:     key_word_1     <= cfg_data;
        CFG_KEY_WORD_2:     key_word_2     <= cfg_data;
        CFG_KEY_WORD_3:     key_word_3     <= cfg_data;
        CFG_DECRYPT_SELECT: decrypt_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Output register frees up when empty or taken; pipeline moves when
  // its last stage is empty or can drain into the output register
  assign out_load    = !result_valid || result_ready;
  assign advance     = !valid_q[LAST] || out_load;
  assign block_ready = advance;

  // Half-round stages: even stages of a round update one word, odd the other
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam int    RND  = s / 2;
    localparam bit    EVEN = (s % 2) == 0;
    localparam word_t ESUM = enc_sum(RND);
    localparam word_t DSUM = dec_sum(RND);

    logic  src_is_b;
    word_t sum;
    word_t m;

    if (s == 0) begin : g_head
      assign a_in[s]     = first_half;
      assign b_in[s]     = second_half;
      assign mode_in[s]  = decrypt_select;
      assign valid_in[s] = block_valid;
    end else begin : g_body
      assign a_in[s]     = a_q[s-1];
      assign b_in[s]     = b_q[s-1];
      assign mode_in[s]  = mode_q[s-1];
      assign valid_in[s] = valid_q[s-1];
    end

    // Encryption mixes b into a first; decryption undoes b first
    assign src_is_b = EVEN ^ mode_in[s];
    assign sum      = mode_in[s] ? DSUM : ESUM;

    always_comb begin
      a_next[s] = a_in[s];
      b_next[s] = b_in[s];
      if (src_is_b) begin
        m = mix(b_in[s], sum, key_word_0, key_word_1);
        a_next[s] = mode_in[s] ? (a_in[s] - m) : (a_in[s] + m);
      end else begin
        m = mix(a_in[s], sum, key_word_2, key_word_3);
        b_next[s] = mode_in[s] ? (b_in[s] - m) : (b_in[s] + m);
      end
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (advance) begin
      for (int i = 0; i < STAGES; i++) begin
        valid_q[i] <= valid_in[i];
      end
    end
  end

  // Advance payload; no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < STAGES; i++) begin
        a_q[i]    <= a_next[i];
        b_q[i]    <= b_next[i];
        mode_q[i] <= mode_in[i];
      end
    end
  end

  // Output register: load from the last stage, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= valid_q[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && valid_q[LAST]) begin
      result_first  <= a_q[LAST];
      result_second <= b_q[LAST];
    end
  end

  // An accepted word lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    block_valid && block_ready |=> valid_q[0])
    else $error("accepted word missing from first stage");

  // A full last stage blocked by the output register keeps its word
  assert property (@(posedge clk) disable iff (rst)
    valid_q[LAST] && !out_load |=> valid_q[LAST] && $stable(a_q[LAST])
      && $stable(b_q[LAST]))
    else $error("last stage lost a word during a stall");

  // A word leaving the last stage shows up at the output
  assert property (@(posedge clk) disable iff (rst)
    valid_q[LAST] && out_load |=> result_valid
      && result_first == $past(a_q[LAST]) && result_second == $past(b_q[LAST]))
    else $error("output register missed a finished word");

  // The pipeline never moves while a full last stage cannot drain
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready && valid_q[LAST] |-> !block_ready)
    else $error("input taken while pipeline is blocked");

endmodule

`default_nettype wire
